/* hdl/qph_pkg.sv */
package qph_pkg;

	// fixed field widths
	localparam int KEY_W  = 32;
	localparam int SLOT_W = 10;
	localparam int CFG_W  = 10;

	localparam logic [CFG_W-1:0] CFG_RESET = 10'd11;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 32;

	// remainder bits resolved per divider cycle
	localparam int RADIX = 4;

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_DONE      = 2'd0,
		RS_NOT_FOUND = 2'd1,
		RS_PRESENT   = 2'd2,
		RS_FULL      = 2'd3
	} rsp_status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY   = 2'd0,
		KIND_LIVE    = 2'd1,
		KIND_DELETED = 2'd2
	} kind_t;

	typedef struct packed {
		op_t              opcode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		rsp_status_t       status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_WIPE,
		ST_IDLE,
		ST_CLEAR,
		ST_MOD,
		ST_HOME,
		ST_READ,
		ST_CHECK,
		ST_FINISH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic probe_init;
		logic rd_en;
		logic check;
		logic finish;
		logic clr_step;
		logic rsp_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic exhausted;
		logic stop;
		logic clr_last;
	} sts_t;

endpackage

/* hdl/qph_mod.sv */
module qph_mod import qph_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        step,
	input  logic [KEY_W-1:0]            key,
	input  logic [$clog2(CAPACITY):0]   n,
	output logic [$clog2(CAPACITY):0]   rem,
	output logic                        last
);

	localparam int NW    = $clog2(CAPACITY) + 1;
	localparam int DW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int STEPS = (DW + RADIX - 1) / RADIX;
	localparam int SW    = STEPS * RADIX;
	localparam int CW    = $clog2(STEPS);

	logic [SW-1:0] dv_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] rem_d;
	logic [CW-1:0] cnt_q;

	// restoring remainder, msb first, RADIX bits per cycle
	always_comb begin
		logic [NW:0] r;
		r = {1'b0, rem_q};
		for (int j = 0; j < RADIX; j++) begin
			r = {r[NW-1:0], dv_q[SW-1-j]};
			if (r >= {1'b0, n}) r = r - {1'b0, n};
		end
		rem_d = r[NW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= last ? '0 : cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= SW'(key[DW-1:0]);
			rem_q <= '0;
		end else if (step) begin
			dv_q  <= dv_q << RADIX;
			rem_q <= rem_d;
		end
	end

	assign last = (cnt_q == CW'(STEPS - 1));
	assign rem  = rem_q;

endmodule

/* hdl/qph_ctrl.sv */
module qph_ctrl import qph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  op_t  req_op,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WIPE:   if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) state_d = (req_op == OP_CLEAR) ? ST_CLEAR : ST_MOD;
			end
			ST_CLEAR:  if (sts.clr_last) state_d = ST_RESP;
			ST_MOD:    if (sts.div_last) state_d = ST_HOME;
			ST_HOME:   state_d = ST_READ;
			ST_READ:   state_d = sts.exhausted ? ST_FINISH : ST_CHECK;
			ST_CHECK:  state_d = sts.stop ? ST_FINISH : ST_READ;
			ST_FINISH: state_d = ST_RESP;
			ST_RESP:   if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_WIPE:   cmd.clr_step = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_CLEAR:  cmd.clr_step = 1'b1;
			ST_MOD:    cmd.div_step = 1'b1;
			ST_HOME:   cmd.probe_init = 1'b1;
			ST_READ:   cmd.rd_en = !sts.exhausted;
			ST_CHECK:  cmd.check = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			ST_RESP:   cmd.rsp_load = !rsp_valid_q || rsp_ready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* hdl/qph_dp.sv */
module qph_dp import qph_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output rsp_t             rsp
);

	localparam int PW = $clog2(CAPACITY);
	localparam int NW = PW + 1;
	localparam int EW = KEY_BITS + 2;

	logic [CFG_W-1:0]    ts_q;
	logic [NW-1:0]       n;
	logic [NW-1:0]       rem;

	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       inc_q;
	logic [NW-1:0]       probes_q;
	logic                have_free_q;
	logic [PW-1:0]       free_q;
	rsp_status_t         status_q;
	logic [PW-1:0]       slot_q;
	logic [PW-1:0]       clr_cnt_q;
	rsp_t                rsp_q;

	logic [EW-1:0]       ent_q [CAPACITY];
	logic [EW-1:0]       rd_q;

	logic                is_empty;
	logic                is_live;
	logic                match;
	logic [PW:0]         pos_sum;
	logic [PW:0]         inc_sum;
	logic [PW-1:0]       pos_nx;
	logic [PW-1:0]       inc_nx;

	logic                we;
	logic [PW-1:0]       wa;
	logic [EW-1:0]       wd;
	logic                del_write;
	logic                ins_write;

	// effective size clamped to 2..CAPACITY
	always_comb begin
		if (ts_q < CFG_W'(2)) begin
			n = NW'(2);
		end else if (32'(ts_q) > 32'(CAPACITY)) begin
			n = NW'(CAPACITY);
		end else begin
			n = NW'(ts_q);
		end
	end

	qph_mod #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.step   (cmd.div_step),
		.key    (req.key),
		.n      (n),
		.rem    (rem),
		.last   (sts.div_last)
	);

	assign is_empty = (rd_q[1:0] == KIND_EMPTY);
	assign is_live  = (rd_q[1:0] == KIND_LIVE);
	assign match    = is_live && (rd_q[EW-1:2] == key_q);

	// quadratic step: pos += inc, inc += 2, both wrapped once
	assign pos_sum = {1'b0, pos_q} + {1'b0, inc_q};
	assign inc_sum = {1'b0, inc_q} + (PW + 1)'(2);
	assign pos_nx  = (pos_sum >= n) ? PW'(pos_sum - n) : pos_sum[PW-1:0];
	assign inc_nx  = (inc_sum >= n) ? PW'(inc_sum - n) : inc_sum[PW-1:0];

	assign sts.exhausted = (probes_q == n);
	assign sts.stop      = is_empty || match;
	assign sts.clr_last  = (clr_cnt_q == PW'(CAPACITY - 1));

	assign del_write = cmd.check && match && (op_q == OP_DELETE);
	assign ins_write = cmd.finish && (op_q == OP_INSERT) && (status_q == RS_FULL)
		&& have_free_q;

	always_comb begin
		we = 1'b1;
		wa = pos_q;
		wd = {key_q, KIND_DELETED};
		priority if (cmd.clr_step) begin
			wa = clr_cnt_q;
			wd = {{KEY_BITS{1'b0}}, KIND_EMPTY};
		end else if (ins_write) begin
			wa = free_q;
			wd = {key_q, KIND_LIVE};
		end else if (del_write) begin
			wa = pos_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) ent_q[wa] <= wd;
		if (cmd.rd_en) rd_q <= ent_q[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q      <= CFG_RESET;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) ts_q <= cfg_data;
			if (cmd.clr_step) clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.opcode;
			key_q    <= KEY_BITS'(req.key);
			status_q <= (req.opcode == OP_CLEAR) ? RS_DONE : RS_FULL;
			slot_q   <= '0;
		end
		if (cmd.probe_init) begin
			pos_q       <= rem[PW-1:0];
			inc_q       <= PW'(1);
			probes_q    <= '0;
			have_free_q <= 1'b0;
		end
		if (cmd.check) begin
			if (is_empty) begin
				if (op_q == OP_INSERT) begin
					if (!have_free_q) begin
						have_free_q <= 1'b1;
						free_q      <= pos_q;
					end
				end else begin
					status_q <= RS_NOT_FOUND;
				end
			end else if (match) begin
				status_q <= (op_q == OP_INSERT) ? RS_PRESENT : RS_DONE;
				slot_q   <= pos_q;
			end else begin
				if (!is_live && !have_free_q) begin
					have_free_q <= 1'b1;
					free_q      <= pos_q;
				end
				pos_q    <= pos_nx;
				inc_q    <= inc_nx;
				probes_q <= probes_q + NW'(1);
			end
		end
		if (ins_write) begin
			status_q <= RS_DONE;
			slot_q   <= free_q;
		end
		if (cmd.rsp_load) begin
			rsp_q.status <= status_q;
			rsp_q.slot   <= SLOT_W'(slot_q);
		end
	end

	assign rsp = rsp_q;

endmodule

/* hdl/quadratic_probe_hash_table.sv */
// find, insert and delete first run the remainder unit, then probe slot after slot, each
// probe a read followed by a compare, until a match, an empty slot or the probes run out;
// the slots probed number 1 to table size; clear empties every slot before giving its word;
// one item at a time, the next is taken the cycle after the result is registered
// reset: a pass over every slot empties the slot memory before the first word is taken
module quadratic_probe_hash_table import qph_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	qph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.opcode),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qph_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("word accepted while another is in flight");

	// misses and full table carry no slot
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == RS_NOT_FOUND || rsp.status == RS_FULL))
			|-> (rsp.slot == '0))
		else $error("slot set on a miss");

	// a new result only follows a finished item, never directly an acceptance
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !$rose(rsp_valid))
		else $error("result raised right after acceptance");

endmodule
